/* rtl/idqs_pkg.sv */
// Shared types and codes for the inverse-distance quadrature sum core.
// No dependencies.
package idqs_pkg;

    // datapath operation codes issued by the controller
    localparam logic [3:0] OP_NONE  = 4'd0;
    localparam logic [3:0] OP_LOAD  = 4'd1;
    localparam logic [3:0] OP_SQ_X  = 4'd2;
    localparam logic [3:0] OP_SQ_Y  = 4'd3;
    localparam logic [3:0] OP_SQ_Z  = 4'd4;
    localparam logic [3:0] OP_SQ_END = 4'd5;
    localparam logic [3:0] OP_CLASS = 4'd6;
    localparam logic [3:0] OP_DIV   = 4'd7;
    localparam logic [3:0] OP_FIX   = 4'd8;
    localparam logic [3:0] OP_SQRT  = 4'd9;
    localparam logic [3:0] OP_MUL   = 4'd10;
    localparam logic [3:0] OP_ACC   = 4'd11;
    localparam logic [3:0] OP_EMIT  = 4'd12;

    // sample classification after the squared distance is known
    localparam logic [1:0] CLS_SKIP  = 2'd0;
    localparam logic [1:0] CLS_FIXED = 2'd1;
    localparam logic [1:0] CLS_DIV   = 2'd2;

    // configuration register indexes
    localparam logic [2:0] REG_SRC_X   = 3'd0;
    localparam logic [2:0] REG_SRC_Y   = 3'd1;
    localparam logic [2:0] REG_SRC_Z   = 3'd2;
    localparam logic [2:0] REG_OBS_X   = 3'd3;
    localparam logic [2:0] REG_OBS_Y   = 3'd4;
    localparam logic [2:0] REG_OBS_Z   = 3'd5;
    localparam logic [2:0] REG_SRC_PL  = 3'd6;
    localparam logic [2:0] REG_OBS_PL  = 3'd7;

    localparam int DIV_STEPS  = 64;
    localparam int SQRT_STEPS = 32;

    typedef struct packed {
        logic [3:0] op;
    } cmd_t;

    typedef struct packed {
        logic [1:0] cls;
        logic       div_end;
        logic       sqrt_end;
        logic       last;
    } stat_t;

endpackage

/* rtl/idqs_dp.sv */
// Datapath: config registers, distance formation, shared multiplier,
// restoring divider, digit-by-digit square root, accumulator. Uses idqs_pkg.
module idqs_dp
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [2:0]           cfg_index,
    input  logic [31:0]          cfg_data,
    input  logic signed [31:0]   offset_a,
    input  logic signed [31:0]   offset_b,
    input  logic signed [31:0]   offset_c,
    input  logic signed [31:0]   offset_d,
    input  logic [31:0]          weight,
    input  logic                 last_sample,
    input  idqs_pkg::cmd_t       cmd,
    output idqs_pkg::stat_t      stat,
    output logic [63:0]          integral,
    output logic                 zero_distance_seen,
    output logic                 saturated
);

    logic signed [31:0] scx_reg, scy_reg, scz_reg, ocx_reg, ocy_reg, ocz_reg;
    logic [1:0]         src_pl_reg, obs_pl_reg;

    logic signed [33:0] dx_reg, dy_reg, dz_reg;
    logic               pair_ok_reg;
    logic               huge_reg;
    logic [31:0]        w_reg;
    logic               last_reg;
    logic [65:0]        prod_reg;
    logic [65:0]        dsum_reg;
    logic [63:0]        rem_reg;
    logic [63:0]        quo_reg;
    logic [63:0]        sq_x_reg, sq_r_reg, sq_bit_reg;
    logic [5:0]         cnt_reg;
    logic [31:0]        recip_reg;
    logic [63:0]        sum_reg;
    logic               zflag_reg, sflag_reg;
    logic [63:0]        out_sum_reg;
    logic               out_z_reg, out_s_reg;

    // distance formation
    logic signed [33:0] a, b, c, d, ocx, ocy, ocz, scx, scy, scz;
    logic signed [33:0] dx_next, dy_next, dz_next;
    logic               pair_ok_next;

    always_comb
    begin
        a   = {{2{offset_a[31]}}, offset_a};
        b   = {{2{offset_b[31]}}, offset_b};
        c   = {{2{offset_c[31]}}, offset_c};
        d   = {{2{offset_d[31]}}, offset_d};
        ocx = {{2{ocx_reg[31]}}, ocx_reg};
        ocy = {{2{ocy_reg[31]}}, ocy_reg};
        ocz = {{2{ocz_reg[31]}}, ocz_reg};
        scx = {{2{scx_reg[31]}}, scx_reg};
        scy = {{2{scy_reg[31]}}, scy_reg};
        scz = {{2{scz_reg[31]}}, scz_reg};
        pair_ok_next = 1'b1;
        dx_next = '0;
        dy_next = '0;
        dz_next = '0;
        case ({src_pl_reg, obs_pl_reg})
            4'd5:
            begin
                dx_next = (a + ocx) - (b + scx); dy_next = (c + ocy) - (d + scy);
                dz_next = ocz - scz;
            end
            4'd10:
            begin
                dx_next = (a + ocx) - (b + scx); dy_next = (c + ocz) - (d + scz);
                dz_next = ocy - scy;
            end
            4'd15:
            begin
                dx_next = (a + ocy) - (b + scy); dy_next = (c + ocz) - (d + scz);
                dz_next = ocx - scx;
            end
            4'd6:
            begin
                dx_next = (a + ocx) - (b + scx); dy_next = ocy - (d + scy);
                dz_next = (c + ocz) - scz;
            end
            4'd7:
            begin
                dx_next = ocx - (a + scx); dy_next = (c + ocy) - (b + scy);
                dz_next = (d + ocz) - scz;
            end
            4'd11:
            begin
                dx_next = ocx - (a + scx); dy_next = (b + ocy) - scy;
                dz_next = (c + ocz) - (d + scz);
            end
            4'd9:
            begin
                dx_next = (a + ocx) - (b + scx); dy_next = (c + ocy) - scy;
                dz_next = ocz - (d + scz);
            end
            4'd13:
            begin
                dx_next = (a + ocx) - scx; dy_next = (b + ocy) - (c + scy);
                dz_next = ocz - (d + scz);
            end
            4'd14:
            begin
                dx_next = (a + ocx) - scx; dy_next = ocy - (c + scy);
                dz_next = (b + ocz) - (d + scz);
            end
            default: pair_ok_next = 1'b0;
        endcase
    end

    // shared multiplier operand select
    logic signed [33:0] dsel;
    logic [33:0]        dabs;
    logic [32:0]        mul_a, mul_b;
    logic [65:0]        mul_p;
    logic               dbig;

    always_comb
    begin
        case (cmd.op)
            idqs_pkg::OP_SQ_X: dsel = dx_reg;
            idqs_pkg::OP_SQ_Y: dsel = dy_reg;
            default:           dsel = dz_reg;
        endcase
        dabs = dsel[33] ? 34'(-dsel) : 34'(dsel);
        dbig = dabs > 34'h1_0000_0000;
        if (cmd.op == idqs_pkg::OP_MUL)
        begin
            mul_a = {1'b0, w_reg};
            mul_b = {1'b0, recip_reg};
        end
        else
        begin
            mul_a = dabs[32:0];
            mul_b = dabs[32:0];
        end
        mul_p = mul_a * mul_b;
    end

    // classification of the squared distance
    logic [63:0] den;
    logic [1:0]  cls;
    always_comb
    begin
        den = dsum_reg[63:0];
        if (!pair_ok_reg || huge_reg || dsum_reg > {2'b01, 64'd0} || dsum_reg == '0)
            cls = idqs_pkg::CLS_SKIP;
        else if (dsum_reg == {2'b01, 64'd0} || dsum_reg == 66'd1)
            cls = idqs_pkg::CLS_FIXED;
        else
            cls = idqs_pkg::CLS_DIV;
    end

    // divider, root and accumulator steps
    logic [64:0] div_t;
    logic        div_ge;
    logic [63:0] q_fix;
    logic [63:0] rb;
    logic        sq_ge;
    logic [63:0] sq_r_step;
    logic [64:0] acc_s;

    always_comb
    begin
        div_t     = {rem_reg, 1'b1};
        div_ge    = div_t >= {1'b0, den};
        q_fix     = quo_reg + {63'd0, rem_reg == (den - 64'd1)};
        rb        = sq_r_reg + sq_bit_reg;
        sq_ge     = sq_x_reg >= rb;
        sq_r_step = sq_ge ? ((sq_r_reg >> 1) + sq_bit_reg) : (sq_r_reg >> 1);
        acc_s     = {1'b0, sum_reg} + {15'd0, prod_reg[63:14]};
    end

    // config registers and accumulation state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scx_reg <= '0; scy_reg <= '0; scz_reg <= '0;
            ocx_reg <= '0; ocy_reg <= '0; ocz_reg <= '0;
            src_pl_reg <= '0; obs_pl_reg <= '0;
            sum_reg <= '0; zflag_reg <= 1'b0; sflag_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    idqs_pkg::REG_SRC_X:  scx_reg <= cfg_data;
                    idqs_pkg::REG_SRC_Y:  scy_reg <= cfg_data;
                    idqs_pkg::REG_SRC_Z:  scz_reg <= cfg_data;
                    idqs_pkg::REG_OBS_X:  ocx_reg <= cfg_data;
                    idqs_pkg::REG_OBS_Y:  ocy_reg <= cfg_data;
                    idqs_pkg::REG_OBS_Z:  ocz_reg <= cfg_data;
                    idqs_pkg::REG_SRC_PL: src_pl_reg <= cfg_data[1:0];
                    idqs_pkg::REG_OBS_PL: obs_pl_reg <= cfg_data[1:0];
                    default: ;
                endcase
            end
            case (cmd.op)
                idqs_pkg::OP_CLASS:
                begin
                    if (pair_ok_reg && !huge_reg && dsum_reg == '0)
                        zflag_reg <= 1'b1;
                    if (pair_ok_reg && !huge_reg && dsum_reg == 66'd1)
                        sflag_reg <= 1'b1;
                end
                idqs_pkg::OP_ACC:
                begin
                    if (acc_s[64])
                    begin
                        sum_reg   <= '1;
                        sflag_reg <= 1'b1;
                    end
                    else
                        sum_reg <= acc_s[63:0];
                end
                idqs_pkg::OP_EMIT:
                begin
                    sum_reg   <= '0;
                    zflag_reg <= 1'b0;
                    sflag_reg <= 1'b0;
                end
                default: ;
            endcase
        end
    end

    // working registers (payload, no reset)
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            idqs_pkg::OP_LOAD:
            begin
                dx_reg <= dx_next; dy_reg <= dy_next; dz_reg <= dz_next;
                pair_ok_reg <= pair_ok_next;
                w_reg <= weight;
                last_reg <= last_sample;
                huge_reg <= 1'b0;
                dsum_reg <= '0;
            end
            idqs_pkg::OP_SQ_X, idqs_pkg::OP_SQ_Y, idqs_pkg::OP_SQ_Z:
            begin
                prod_reg <= mul_p;
                huge_reg <= huge_reg | dbig;
                if (cmd.op != idqs_pkg::OP_SQ_X)
                    dsum_reg <= dsum_reg + prod_reg;
            end
            idqs_pkg::OP_SQ_END: dsum_reg <= dsum_reg + prod_reg;
            idqs_pkg::OP_CLASS:
            begin
                cnt_reg   <= '0;
                rem_reg   <= '0;
                quo_reg   <= '0;
                recip_reg <= (dsum_reg == 66'd1) ? 32'hFFFF_FFFF : 32'd1;
            end
            idqs_pkg::OP_DIV:
            begin
                // a set top bit of div_t always means div_ge, so 64 bits hold the remainder
                rem_reg <= div_ge ? 64'(div_t - {1'b0, den}) : div_t[63:0];
                quo_reg <= {quo_reg[62:0], div_ge};
                cnt_reg <= cnt_reg + 6'd1;
            end
            idqs_pkg::OP_FIX:
            begin
                sq_x_reg   <= q_fix;
                sq_r_reg   <= '0;
                sq_bit_reg <= 64'h4000_0000_0000_0000;
                cnt_reg    <= '0;
            end
            idqs_pkg::OP_SQRT:
            begin
                if (sq_ge)
                    sq_x_reg <= sq_x_reg - rb;
                sq_r_reg   <= sq_r_step;
                recip_reg  <= sq_r_step[31:0];
                sq_bit_reg <= sq_bit_reg >> 2;
                cnt_reg    <= cnt_reg + 6'd1;
            end
            idqs_pkg::OP_MUL: prod_reg <= mul_p;
            idqs_pkg::OP_EMIT:
            begin
                out_sum_reg <= sum_reg;
                out_z_reg   <= zflag_reg;
                out_s_reg   <= sflag_reg;
            end
            default: ;
        endcase
    end

    assign stat.cls      = cls;
    assign stat.div_end  = cnt_reg == 6'(idqs_pkg::DIV_STEPS - 1);
    assign stat.sqrt_end = cnt_reg == 6'(idqs_pkg::SQRT_STEPS - 1);
    assign stat.last     = last_reg;

    assign integral           = out_sum_reg;
    assign zero_distance_seen = out_z_reg;
    assign saturated          = out_s_reg;

endmodule

/* rtl/idqs_ctrl.sv */
// Controller: sequences one sample through the datapath and owns both
// channel handshakes. Uses idqs_pkg.
module idqs_ctrl
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    output logic             out_valid,
    input  logic             out_stall,
    input  idqs_pkg::stat_t  stat,
    output idqs_pkg::cmd_t   cmd
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_SQ0  = 4'd1;
    localparam logic [3:0] S_SQ1  = 4'd2;
    localparam logic [3:0] S_SQ2  = 4'd3;
    localparam logic [3:0] S_SQ3  = 4'd4;
    localparam logic [3:0] S_CLS  = 4'd5;
    localparam logic [3:0] S_DIV  = 4'd6;
    localparam logic [3:0] S_FIX  = 4'd7;
    localparam logic [3:0] S_SQRT = 4'd8;
    localparam logic [3:0] S_MUL  = 4'd9;
    localparam logic [3:0] S_ACC  = 4'd10;
    localparam logic [3:0] S_FIN  = 4'd11;

    logic [3:0] state_reg, state_next;
    logic       oval_reg, oval_next;
    logic       accept, slot_free, emit;

    assign accept    = in_valid && (state_reg == S_IDLE);
    assign slot_free = !oval_reg || !out_stall;
    assign emit      = (state_reg == S_FIN) && stat.last && slot_free;

    always_comb
    begin
        state_next = state_reg;
        cmd.op     = idqs_pkg::OP_NONE;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op     = idqs_pkg::OP_LOAD;
                    state_next = S_SQ0;
                end
            end
            S_SQ0: begin cmd.op = idqs_pkg::OP_SQ_X;   state_next = S_SQ1; end
            S_SQ1: begin cmd.op = idqs_pkg::OP_SQ_Y;   state_next = S_SQ2; end
            S_SQ2: begin cmd.op = idqs_pkg::OP_SQ_Z;   state_next = S_SQ3; end
            S_SQ3: begin cmd.op = idqs_pkg::OP_SQ_END; state_next = S_CLS; end
            S_CLS:
            begin
                cmd.op = idqs_pkg::OP_CLASS;
                case (stat.cls)
                    idqs_pkg::CLS_FIXED: state_next = S_MUL;
                    idqs_pkg::CLS_DIV:   state_next = S_DIV;
                    default:             state_next = S_FIN;
                endcase
            end
            S_DIV:
            begin
                cmd.op = idqs_pkg::OP_DIV;
                if (stat.div_end)
                    state_next = S_FIX;
            end
            S_FIX: begin cmd.op = idqs_pkg::OP_FIX; state_next = S_SQRT; end
            S_SQRT:
            begin
                cmd.op = idqs_pkg::OP_SQRT;
                if (stat.sqrt_end)
                    state_next = S_MUL;
            end
            S_MUL: begin cmd.op = idqs_pkg::OP_MUL; state_next = S_ACC; end
            S_ACC: begin cmd.op = idqs_pkg::OP_ACC; state_next = S_FIN; end
            S_FIN:
            begin
                if (!stat.last)
                    state_next = S_IDLE;
                else if (slot_free)
                begin
                    cmd.op     = idqs_pkg::OP_EMIT;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        oval_next = oval_reg;
        if (oval_reg && !out_stall)
            oval_next = 1'b0;
        if (emit)
            oval_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            oval_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            oval_reg  <= oval_next;
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = oval_reg;

    // a result only appears from the finishing step
    a_emit_only: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(oval_reg) |-> $past(state_reg) == S_FIN)
        else $error("result valid without finishing step");

    // an accepted sample always starts the squaring sequence
    a_accept_seq: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg == S_SQ0)
        else $error("accepted sample did not start");

    // a pending result is never overwritten by the next emit
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (oval_reg && out_stall) |-> !emit)
        else $error("result overwritten while stalled");

endmodule

/* rtl/inverse_distance_quadrature_sum_core.sv */
// Top level of the inverse-distance quadrature sum core.
// Instantiates idqs_ctrl and idqs_dp; uses idqs_pkg.
//
//  channel  dir  handshake            payload
//  in       in   in_valid/in_stall    offset_a..d, weight, last_sample
//  out      out  out_valid/out_stall  integral, zero_distance_seen, saturated
//  cfg      in   cfg_we               cfg_index, cfg_data
//
// A sample is skipped on bad pairing or a zero or huge distance, gets a
// fixed reciprocal on a unit or 2^64 distance squared, and otherwise goes
// through a 64-step 1-bit restoring divider and a 32-step 2-bit root
// recurrence. One 33x33 multiplier serves the three squares and the weight
// product. Reset clears config, the running sum and flags. A stalled result
// holds; the next sample is still accepted and only the finishing step of a
// last sample waits for the output register.
module inverse_distance_quadrature_sum_core
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [2:0]          cfg_index,
    input  logic [31:0]         cfg_data,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic signed [31:0]  offset_a,
    input  logic signed [31:0]  offset_b,
    input  logic signed [31:0]  offset_c,
    input  logic signed [31:0]  offset_d,
    input  logic [31:0]         weight,
    input  logic                last_sample,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [63:0]         integral,
    output logic                zero_distance_seen,
    output logic                saturated
);

    idqs_pkg::cmd_t  cmd;
    idqs_pkg::stat_t stat;

    idqs_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    idqs_dp u_dp
    (
        .clk                (clk),
        .rst_n              (rst_n),
        .cfg_we             (cfg_we),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .offset_a           (offset_a),
        .offset_b           (offset_b),
        .offset_c           (offset_c),
        .offset_d           (offset_d),
        .weight             (weight),
        .last_sample        (last_sample),
        .cmd                (cmd),
        .stat               (stat),
        .integral           (integral),
        .zero_distance_seen (zero_distance_seen),
        .saturated          (saturated)
    );

endmodule

/* tb/sv/tb_inverse_distance_quadrature_sum_core.sv */
`timescale 1ns / 100ps
// Self-checking testbench for inverse_distance_quadrature_sum_core.
// Depends on idqs_pkg and the core RTL; runs a directed table, then randomized phases.
module tb_inverse_distance_quadrature_sum_core;

    // normal-axis codes of the plane registers
    localparam logic [1:0] PLANE_NONE = 2'd0;
    localparam logic [1:0] PLANE_Z    = 2'd1;
    localparam logic [1:0] PLANE_Y    = 2'd2;
    localparam logic [1:0] PLANE_X    = 2'd3;

    localparam int  CYCLE_LIMIT  = 1000000;
    localparam int  SETTLE       = 200;   // > the slowest sample's latency
    localparam int  NUM_PHASES   = 8;
    localparam int  PHASE_ITEMS  = 116;
    localparam logic [31:0] W_ONE = 32'h4000_0000;  // 1.0 in Q2.30

    typedef struct {
        logic [63:0] integral;
        logic        zero_seen;
        logic        sat;
    } quad_result_t;

    typedef struct {
        logic [1:0]   sp;
        logic [1:0]   op;
        logic [31:0]  a, b, c, d, w;
        logic         last;
        bit           typed;
        quad_result_t res;
    } quad_row_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_we = 1'b0;
    logic [2:0]         cfg_index = idqs_pkg::REG_SRC_X;
    logic [31:0]        cfg_data = '0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic signed [31:0] offset_a = '0;
    logic signed [31:0] offset_b = '0;
    logic signed [31:0] offset_c = '0;
    logic signed [31:0] offset_d = '0;
    logic [31:0]        weight = '0;
    logic               last_sample = 1'b0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic [63:0]        integral;
    logic               zero_distance_seen;
    logic               saturated;

    // predictor copy of configuration and accumulator state
    longint      src_ctr [3];
    longint      obs_ctr [3];
    logic [1:0]  src_pl, obs_pl;
    logic [63:0] sum_acc;
    logic        zero_acc, sat_acc;

    quad_result_t pending_sums[$];   // integrals still owed by the core
    quad_row_t    rows[$];
    int           mismatches = 0;
    int           samples_in = 0;
    int           cycles = 0;
    int           burst_left = 0;

    inverse_distance_quadrature_sum_core i_dut (
        .clk                (clk),
        .rst_n              (rst_n),
        .cfg_we             (cfg_we),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .in_valid           (in_valid),
        .in_stall           (in_stall),
        .offset_a           (offset_a),
        .offset_b           (offset_b),
        .offset_c           (offset_c),
        .offset_d           (offset_d),
        .weight             (weight),
        .last_sample        (last_sample),
        .out_valid          (out_valid),
        .out_stall          (out_stall),
        .integral           (integral),
        .zero_distance_seen (zero_distance_seen),
        .saturated          (saturated)
    );

    always #1 clk = ~clk;

    // Global watchdog.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // floor(sqrt(x)), bit by bit
    function automatic logic [31:0] int_root(input logic [63:0] x);
        logic [31:0] r;
        logic [31:0] t;
        r = '0;
        for (int i = 31; i >= 0; i--)
        begin
            t = r | (32'd1 << i);
            if ({32'd0, t} * {32'd0, t} <= x)
                r = t;
        end
        return r;
    endfunction

    // Q16.16 reciprocal distance, truncated. Zero distance reported separately.
    function automatic void recip_distance(input longint dx, input longint dy,
                                           input longint dz,
                                           output logic [31:0] recip,
                                           output bit is_zero, output bit clipped);
        logic [71:0] ux, uy, uz, dsq;
        logic [64:0] q;
        ux = (dx < 0) ? 72'(-dx) : 72'(dx);
        uy = (dy < 0) ? 72'(-dy) : 72'(dy);
        uz = (dz < 0) ? 72'(-dz) : 72'(dz);
        dsq = ux * ux + uy * uy + uz * uz;
        is_zero = 0;
        clipped = 0;
        recip = '0;
        if (dsq > 72'h1_0000_0000_0000_0000)
            recip = '0;
        else if (dsq == 72'h1_0000_0000_0000_0000)
            recip = 32'd1;
        else if (dsq == 0)
            is_zero = 1;
        else if (dsq == 1)
        begin
            recip = 32'hFFFF_FFFF;
            clipped = 1;
        end
        else
        begin
            q = (65'd1 << 64) / dsq[64:0];
            recip = int_root(q[63:0]);
        end
    endfunction

    // Advance the accumulator by one sample; returns 1 when a result is due.
    function automatic bit accumulate_sample(input logic [31:0] ra, rb, rc, rd, w,
                                             input logic last,
                                             output quad_result_t res);
        longint a, b, c, d, dx, dy, dz;
        longint scx, scy, scz, ocx, ocy, ocz;
        bit paired, is_zero, clipped;
        logic [31:0] recip;
        logic [63:0] contrib;
        logic [64:0] s;
        a = longint'(signed'(ra));
        b = longint'(signed'(rb));
        c = longint'(signed'(rc));
        d = longint'(signed'(rd));
        scx = src_ctr[0]; scy = src_ctr[1]; scz = src_ctr[2];
        ocx = obs_ctr[0]; ocy = obs_ctr[1]; ocz = obs_ctr[2];
        paired = 1;
        dx = 0; dy = 0; dz = 0;
        case ({src_pl, obs_pl})
            {PLANE_Z, PLANE_Z}: begin dx = (a+ocx)-(b+scx); dy = (c+ocy)-(d+scy); dz = ocz-scz; end
            {PLANE_Y, PLANE_Y}: begin dx = (a+ocx)-(b+scx); dy = (c+ocz)-(d+scz); dz = ocy-scy; end
            {PLANE_X, PLANE_X}: begin dx = (a+ocy)-(b+scy); dy = (c+ocz)-(d+scz); dz = ocx-scx; end
            {PLANE_Z, PLANE_Y}: begin dx = (a+ocx)-(b+scx); dy = ocy-(d+scy); dz = (c+ocz)-scz; end
            {PLANE_Z, PLANE_X}: begin dx = ocx-(a+scx); dy = (c+ocy)-(b+scy); dz = (d+ocz)-scz; end
            {PLANE_Y, PLANE_X}: begin dx = ocx-(a+scx); dy = (b+ocy)-scy; dz = (c+ocz)-(d+scz); end
            {PLANE_Y, PLANE_Z}: begin dx = (a+ocx)-(b+scx); dy = (c+ocy)-scy; dz = ocz-(d+scz); end
            {PLANE_X, PLANE_Z}: begin dx = (a+ocx)-scx; dy = (b+ocy)-(c+scy); dz = ocz-(d+scz); end
            {PLANE_X, PLANE_Y}: begin dx = (a+ocx)-scx; dy = ocy-(c+scy); dz = (b+ocz)-(d+scz); end
            default: paired = 0;
        endcase
        if (paired)
        begin
            recip_distance(dx, dy, dz, recip, is_zero, clipped);
            if (clipped)
                sat_acc = 1;
            if (is_zero)
                zero_acc = 1;
            else
            begin
                contrib = ({32'd0, w} * {32'd0, recip}) >> 14;
                s = {1'b0, sum_acc} + {1'b0, contrib};
                if (s[64])
                begin
                    sum_acc = '1;
                    sat_acc = 1;
                end
                else
                    sum_acc = s[63:0];
            end
        end
        res.integral  = sum_acc;
        res.zero_seen = zero_acc;
        res.sat       = sat_acc;
        if (last)
        begin
            sum_acc = '0;
            zero_acc = 0;
            sat_acc = 0;
        end
        return last;
    endfunction

    // One register write, then the write port is left idle before returning.
    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            idqs_pkg::REG_SRC_X:  src_ctr[0] = longint'(signed'(val));
            idqs_pkg::REG_SRC_Y:  src_ctr[1] = longint'(signed'(val));
            idqs_pkg::REG_SRC_Z:  src_ctr[2] = longint'(signed'(val));
            idqs_pkg::REG_OBS_X:  obs_ctr[0] = longint'(signed'(val));
            idqs_pkg::REG_OBS_Y:  obs_ctr[1] = longint'(signed'(val));
            idqs_pkg::REG_OBS_Z:  obs_ctr[2] = longint'(signed'(val));
            idqs_pkg::REG_SRC_PL: src_pl = val[1:0];
            idqs_pkg::REG_OBS_PL: obs_pl = val[1:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    // Drain the core before touching configuration.
    task automatic wait_idle();
        in_valid <= 1'b0;
        burst_left = 0;
        while (pending_sums.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // One input transfer; bursts of random length with random gaps.
    task automatic send_sample(input logic [31:0] a, b, c, d, w, input logic last,
                               input bit typed, input quad_result_t typed_res);
        quad_result_t res;
        if (burst_left == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                      : $urandom_range(1, 12);
        end
        in_valid    <= 1'b1;
        offset_a    <= a;
        offset_b    <= b;
        offset_c    <= c;
        offset_d    <= d;
        weight      <= w;
        last_sample <= last;
        do
            @(posedge clk);
        while (in_stall);
        samples_in++;
        burst_left--;
        if (accumulate_sample(a, b, c, d, w, last, res))
            pending_sums.push_back(typed ? typed_res : res);
    endtask

    // Result checking against the oldest expectation.
    always @(posedge clk)
    begin
        quad_result_t exp_res;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_sums.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: integral=%h zero=%b sat=%b",
                             integral, zero_distance_seen, saturated);
            end
            else
            begin
                exp_res = pending_sums.pop_front();
                if (integral !== exp_res.integral || zero_distance_seen !== exp_res.zero_seen
                    || saturated !== exp_res.sat)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch: integral exp %h got %h, ",
                                  "zero exp %b got %b, sat exp %b got %b"},
                                 exp_res.integral, integral, exp_res.zero_seen,
                                 zero_distance_seen, exp_res.sat, saturated);
                end
            end
        end
    end

    // Receiver: its own stall pattern, plus one long hold-off so the core
    // backs up and stalls its input.
    initial
    begin
        bit held;
        int mode;
        held = 0;
        @(posedge rst_n);
        forever
        begin
            if (!held && samples_in >= 300)
            begin
                held = 1;
                out_stall <= 1'b1;
                repeat (3000) @(posedge clk);
            end
            mode = $urandom_range(0, 3);
            repeat ($urandom_range(1, 40))
            begin
                case (mode)
                    0: out_stall <= 1'b0;
                    1: out_stall <= $urandom_range(0, 1);
                    2: out_stall <= ($urandom_range(0, 3) != 0);
                    default: out_stall <= ~out_stall;
                endcase
                @(posedge clk);
            end
        end
    end

    function automatic logic [31:0] pick_offset();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            2, 3: return $urandom;
            4: return 32'($urandom_range(0, 3)) - 32'd1;
            default: return 32'($urandom_range(0, 32'h20_0000)) - 32'h10_0000;
        endcase
    endfunction

    task automatic add_row(input logic [1:0] sp, op, input logic [31:0] a, b, c, d, w,
                           input logic last, input bit typed,
                           input logic [63:0] e_int, input logic e_zero, e_sat);
        quad_row_t r;
        r.sp = sp; r.op = op;
        r.a = a; r.b = b; r.c = c; r.d = d; r.w = w;
        r.last = last; r.typed = typed;
        r.res.integral = e_int; r.res.zero_seen = e_zero; r.res.sat = e_sat;
        rows.push_back(r);
    endtask

    initial
    begin
        logic [31:0] a, b, c, d, ctr;
        logic [1:0]  sp, op;
        int          centre_mode;
        for (int i = 0; i < 3; i++)
        begin
            src_ctr[i] = 0;
            obs_ctr[i] = 0;
        end
        src_pl = PLANE_NONE; obs_pl = PLANE_NONE;
        sum_acc = '0; zero_acc = 0; sat_acc = 0;

        // Directed table. Typed expectations only where obvious.
        add_row(PLANE_NONE, PLANE_NONE, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                32'h8000_0000, 32'hFFFF_FFFF, 1, 1, 64'd0, 0, 0);  // after reset: no pairing
        add_row(PLANE_Z, PLANE_Z, 0, 0, 0, 0, 32'hFFFF_FFFF, 1, 1, 64'd0, 1, 0);  // zero distance
        add_row(PLANE_Z, PLANE_Z, 1, 0, 0, 0, W_ONE, 1, 1,
                64'h0000_FFFF_FFFF_0000, 0, 1);                     // reciprocal clips
        add_row(PLANE_Z, PLANE_Z, 32'h0001_0000, 0, 0, 0, W_ONE, 1, 1,
                64'h1_0000_0000, 0, 0);                             // r = 1.0
        add_row(PLANE_Z, PLANE_Z, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                32'h8000_0000, 32'hFFFF_FFFF, 1, 1, 64'd0, 0, 0);  // huge distance
        add_row(PLANE_Z, PLANE_Z, 32'h7FFF_FFFF, 32'h8000_0000, 0, 0,
                32'hFFFF_FFFF, 1, 1, 64'h3FFFF, 0, 0);              // recip truncates to 1
        add_row(PLANE_Z, PLANE_Z, 0, 0, 0, 0, 32'd0, 0, 0, 0, 0, 0);
        add_row(PLANE_Z, PLANE_Z, 32'h100, 0, 32'h300, 0, 32'h0123_4567, 0, 0, 0, 0, 0);
        add_row(PLANE_Z, PLANE_Z, 1, 0, 0, 0, 32'hFFFF_FFFF, 1, 0, 0, 0, 0);
        add_row(PLANE_Y, PLANE_Y, 32'h0003_0039, 32'hFFFF_FCF7, 32'h0000_8000,
                32'hFFFE_0000, W_ONE, 1, 0, 0, 0, 0);
        add_row(PLANE_X, PLANE_X, 32'h0001_2000, 32'h0000_0400, 32'hFFFF_0000,
                32'h0002_0000, 32'h8000_0000, 1, 0, 0, 0, 0);
        add_row(PLANE_Z, PLANE_Y, 32'h0000_4000, 32'h0000_1000, 32'h0005_0000,
                32'h0000_0100, 32'hC000_0000, 1, 0, 0, 0, 0);
        add_row(PLANE_Z, PLANE_X, 32'h0000_0040, 32'hFFFF_FF00, 32'h0000_0800,
                32'h0000_2000, W_ONE, 1, 0, 0, 0, 0);
        add_row(PLANE_Y, PLANE_X, 32'h0000_0001, 32'h0000_0002, 32'h0000_0003,
                32'h0000_0004, 32'hFFFF_FFFF, 1, 0, 0, 0, 0);
        add_row(PLANE_Y, PLANE_Z, 32'h0010_0000, 32'h0008_0000, 32'hFFF0_0000,
                32'h0000_0000, W_ONE, 1, 0, 0, 0, 0);
        add_row(PLANE_X, PLANE_Z, 32'h0000_1234, 32'h0000_5678, 32'hFFFF_9ABC,
                32'h0000_DEF0, 32'h1234_5678, 1, 0, 0, 0, 0);
        add_row(PLANE_X, PLANE_Y, 32'h7FFF_0000, 32'h0000_0010, 32'h8000_0000,
                32'h0000_0020, W_ONE, 1, 0, 0, 0, 0);
        add_row(PLANE_NONE, PLANE_Y, 1, 2, 3, 4, 32'hFFFF_FFFF, 1, 1, 64'd0, 0, 0);
        add_row(PLANE_X, PLANE_NONE, 1, 2, 3, 4, 32'hFFFF_FFFF, 1, 1, 64'd0, 0, 0);

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (rows[i])
        begin
            if (rows[i].sp != src_pl || rows[i].op != obs_pl)
            begin
                wait_idle();
                write_reg(idqs_pkg::REG_SRC_PL, {30'd0, rows[i].sp});
                write_reg(idqs_pkg::REG_OBS_PL, {30'd0, rows[i].op});
            end
            send_sample(rows[i].a, rows[i].b, rows[i].c, rows[i].d, rows[i].w,
                        rows[i].last, rows[i].typed, rows[i].res);
        end

        // Random phases, each under its own configuration.
        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            wait_idle();
            centre_mode = (ph < 3) ? ph : $urandom_range(2, 4);
            for (int k = 0; k < 6; k++)
            begin
                case (centre_mode)
                    0: ctr = (k < 3) ? 32'h7FFF_FFFF : 32'h8000_0000;
                    1: ctr = '0;
                    2: ctr = $urandom;
                    3: ctr = (k < 3) ? 32'h0004_0000 : 32'h0004_0000;  // coincident centres
                    default: ctr = 32'($urandom_range(0, 32'h40_0000)) - 32'h20_0000;
                endcase
                write_reg(3'(k), ctr);
            end
            sp = ($urandom_range(0, 7) == 0) ? PLANE_NONE : 2'($urandom_range(1, 3));
            op = ($urandom_range(0, 7) == 0) ? PLANE_NONE : 2'($urandom_range(1, 3));
            write_reg(idqs_pkg::REG_SRC_PL, {30'($urandom), sp});
            write_reg(idqs_pkg::REG_OBS_PL, {30'($urandom), op});
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                a = pick_offset(); b = pick_offset();
                c = pick_offset(); d = pick_offset();
                if ($urandom_range(0, 9) == 0)
                begin
                    b = a;  // aim for coincident points
                    d = c;
                end
                send_sample(a, b, c, d,
                            ($urandom_range(0, 5) == 0) ? W_ONE : $urandom,
                            (n == PHASE_ITEMS - 1) || ($urandom_range(0, 3) == 0),
                            0, '{default: '0});
            end
        end

        in_valid <= 1'b0;
        while (pending_sums.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

/* sim.f */
rtl/idqs_pkg.sv
rtl/idqs_dp.sv
rtl/idqs_ctrl.sv
rtl/inverse_distance_quadrature_sum_core.sv
tb/sv/tb_inverse_distance_quadrature_sum_core.sv
